[hw/rtl/ula_pkg.sv]
package ula_pkg;

  localparam int LINE_BYTES_DEF = 32;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_OVF  = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_error;
    logic       overrun_error;
  } in_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] line_byte;
    logic [5:0] position;
    logic [6:0] line_length;
    logic       last;
  } out_req_t;

  typedef struct packed {
    logic       wr_en;
    logic       shift;
    logic [7:0] wr_byte;
  } cell_ctl_t;

endpackage

[hw/rtl/ula_cell.sv]
module ula_cell import ula_pkg::*; #(
  parameter int FW    = 6,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [FW-1:0] fill,
  input  logic [7:0]    shift_in,
  output logic [7:0]    data_q
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    if (ctl.wr_en && (fill == FW'(INDEX))) begin
      data_nxt = ctl.wr_byte;
    end else if (ctl.shift) begin
      data_nxt = shift_in;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[hw/rtl/uart_line_assembler_core.sv]
// UART receive line assembler.
// Input channel (in_valid / in_stall / in_data): one received byte per request
// with framing-error and overrun flags. Bytes with an error flag are dropped.
// Ordinary bytes are stored in a row of byte cells, one request per cycle while in_stall is low.
// LF, CR or NUL after at least one stored byte ends the line: the line leaves
// on the output channel (out_valid / out_stall / out_data) as one request per
// byte, position 0 first, each carrying the line length, the final one marked
// last. A byte arriving while the row is full discards the line and gives one
// overflow request instead.
// Once the terminator is accepted the line state is entered, then the first
// byte is registered into the output register; the rest follow one byte per cycle
// while out_stall is low. in_stall is high while a line or overflow is sent;
// the drain rate is set by the cell row shifting one position per byte sent.
// The output register lets a new byte be accepted while the final result of
// a line still waits. A stalled output holds its request and pauses the drain.
// Reset empties the line and clears out_valid; no clearing pass is needed.
module uart_line_assembler_core import ula_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  localparam int FW = $clog2(LINE_BYTES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LINE = 3'b010,
    ST_OVF  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] pos_r, pos_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_req_t      out_data_r, out_data_nxt;
  cell_ctl_t     ctl;
  logic [7:0]    cell_q [LINE_BYTES];

  logic in_fire, byte_ok, is_term, full, out_free, line_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign byte_ok   = !in_data.frame_error && !in_data.overrun_error;
  assign is_term   = (in_data.rx_byte == CHAR_LF) || (in_data.rx_byte == CHAR_CR) ||
                     (in_data.rx_byte == CHAR_NUL);
  assign full      = (fill_r == FW'(LINE_BYTES));
  assign out_free  = !out_valid_r || !out_stall;
  assign line_last = ((pos_r + FW'(1)) == fill_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && byte_ok) begin
          if (full) begin
            state_nxt = ST_OVF;
          end else if (!is_term) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_byte = in_data.rx_byte;
            fill_nxt    = fill_r + FW'(1);
          end else if (fill_r != '0) begin
            state_nxt = ST_LINE;
            pos_nxt   = '0;
          end
        end
      end
      ST_LINE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_LINE;
          out_data_nxt.line_byte   = cell_q[0];
          out_data_nxt.position    = 6'(pos_r);
          out_data_nxt.line_length = 7'(fill_r);
          out_data_nxt.last        = line_last;
          ctl.shift                = 1'b1;
          pos_nxt                  = pos_r + FW'(1);
          if (line_last) begin
            state_nxt = ST_IDLE;
            fill_nxt  = '0;
          end
        end
      end
      ST_OVF: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_OVF;
          out_data_nxt.line_byte   = 8'h00;
          out_data_nxt.position    = 6'd0;
          out_data_nxt.line_length = 7'd0;
          out_data_nxt.last        = 1'b1;
          fill_nxt                 = '0;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // byte cells, head at index 0, shifting toward the head on drain
  for (genvar i = 0; i < LINE_BYTES; i++) begin : g_cell
    if (i == LINE_BYTES - 1) begin : g_tail
      ula_cell #(.FW(FW), .INDEX(i)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .fill     (fill_r),
        .shift_in (8'h00),
        .data_q   (cell_q[i])
      );
    end else begin : g_body
      ula_cell #(.FW(FW), .INDEX(i)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .fill     (fill_r),
        .shift_in (cell_q[i+1]),
        .data_q   (cell_q[i])
      );
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/ula_checker.sv]
module ula_checker import ula_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output request changed");

  a_ovf_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_OVF) |->
      out_data.last && (out_data.line_length == 7'd0) && (out_data.position == 6'd0))
    else $error("overflow request fields wrong");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_LINE) |->
      ({1'b0, out_data.position} < out_data.line_length))
    else $error("line position beyond length");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_LINE) |->
      (out_data.last == (({1'b0, out_data.position} + 7'd1) == out_data.line_length)))
    else $error("last mark not on final byte");

endmodule

bind uart_line_assembler_core ula_checker u_ula_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
